// ===== rtl/dicc_pkg.sv =====
// Shared types and constants for the delay-insensitive code converter.
`timescale 1ns / 1ps

package dicc_pkg;

  // Largest rail count the converter accepts, and the width of a decoded value.
  localparam int unsigned MAX_RAILS  = 64;
  localparam int unsigned VALUE_BITS = 32;

  // First value that no longer fits in VALUE_BITS.
  localparam logic [32:0] VALUE_LIMIT = 33'd1 << VALUE_BITS;

  // Stream and register port widths.
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Code types held in the code_type register.
  localparam logic [1:0] CODE_ONE_OF_N    = 2'd0;
  localparam logic [1:0] CODE_DUAL_RAIL   = 2'd1;
  localparam logic [1:0] CODE_ONE_OF_FOUR = 2'd2;

  // Operation modes carried with each item.
  localparam logic [1:0] MODE_ENCODE = 2'd0;
  localparam logic [1:0] MODE_CHECK  = 2'd2;

  // Register selects, taken from the word address.
  localparam logic REG_CODE_TYPE   = 1'b0;
  localparam logic REG_DIGIT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_NEUTRAL = 2'd1,
    ST_RAILERR = 2'd2,
    ST_TOOBIG  = 2'd3
  } dicc_status_t;

  typedef enum logic [1:0] {
    CK_MATCH    = 2'd0,
    CK_IGNORED  = 2'd1,
    CK_MISMATCH = 2'd2,
    CK_NONE     = 2'd3
  } dicc_check_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value_in;
    logic [63:0] rails_in;
    logic [32:0] expected;
  } dicc_item_t;

  typedef struct packed {
    logic [63:0]  rails_out;
    logic [31:0]  value_out;
    dicc_status_t status;
    dicc_check_t  check_result;
  } dicc_result_t;

endpackage

// ===== rtl/delay_insensitive_code_converter.sv =====
// Top level: stream pipeline and register port around the code conversion logic.
// A result passes from the input register through the conversion logic into the result
// register. Throughput: one item per cycle; the input stalls only while both registers hold
// items and out_tready is low, so at most one more item is taken while a result waits.
// Reset (synchronous, rst_n low) empties both registers and sets code_type 0, digit_count 1.
`timescale 1ns / 1ps

module delay_insensitive_code_converter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode[1:0], value_in[33:2], rails_in[97:34], expected[130:98], zero fill
  input  logic [dicc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // rails_out[63:0], value_out[95:64], status[97:96], check_result[99:98], zero fill
  output logic [dicc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [dicc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [dicc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [dicc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import dicc_pkg::*;

  logic [1:0]   code_type_r;
  logic [6:0]   digit_count_r;
  logic         cfg_wr;

  logic         s1_valid_r;
  dicc_item_t   s1_item_r;
  dicc_item_t   in_item;
  logic         out_valid_r;
  dicc_result_t out_result_r;
  dicc_result_t core_result;

  logic         out_adv;
  logic         s1_adv;

  // Register port: always ready, written on the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CODE_TYPE:   cfg_prdata = {30'd0, code_type_r};
      REG_DIGIT_COUNT: cfg_prdata = {25'd0, digit_count_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_type_r   <= CODE_ONE_OF_N;
      digit_count_r <= 7'd1;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_CODE_TYPE) begin
        code_type_r <= cfg_pwdata[1:0];
      end else begin
        digit_count_r <= cfg_pwdata[6:0];
      end
    end
  end

  // Input unpacking.
  assign in_item.mode     = in_tdata[1:0];
  assign in_item.value_in = in_tdata[33:2];
  assign in_item.rails_in = in_tdata[97:34];
  assign in_item.expected = in_tdata[130:98];

  // Pipeline advance: each stage moves when the one after it is free.
  assign out_adv   = ~out_valid_r | out_tready;
  assign s1_adv    = ~s1_valid_r | out_adv;
  assign in_tready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (out_adv && s1_valid_r) begin
      out_result_r <= core_result;
    end
  end

  dicc_core u_core (
    .code_type   (code_type_r),
    .digit_count (digit_count_r),
    .item        (s1_item_r),
    .result      (core_result)
  );

  // Output packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_result_r.check_result, out_result_r.status,
                       out_result_r.value_out, out_result_r.rails_out};

endmodule

// ===== rtl/dicc_core.sv =====
// Combinational encode, decode and check of one item against the current code setup.
`timescale 1ns / 1ps

module dicc_core (
  input  logic [1:0]            code_type,
  input  logic [6:0]            digit_count,
  input  dicc_pkg::dicc_item_t  item,
  output dicc_pkg::dicc_result_t result
);
  import dicc_pkg::*;

  logic [8:0]  rail_cnt;
  logic        cfg_ok;
  logic [63:0] rail_en;
  logic [31:0] digit_en;
  logic [63:0] r;

  logic [31:0] v;
  logic        v_fit;
  logic        over_n;
  logic        over_d;
  logic        over_q;
  logic [63:0] pat_n;
  logic [63:0] pat_d;
  logic [63:0] pat_q;
  logic        enc_ok;
  logic [63:0] enc_pat;

  logic [5:0]  idx_n;
  logic        onehot_n;
  logic        multi_d, neut_d, live_d;
  logic        multi_q, neut_q, live_q;
  logic [31:0] val_d;
  logic [31:0] val_q;
  logic [31:0] dec_val;
  logic        dec_err;
  dicc_status_t dec_status;

  // Rail count of the configured code; zero marks a setup that cannot be used.
  always_comb begin
    case (code_type)
      CODE_ONE_OF_N:    rail_cnt = {2'b00, digit_count};
      CODE_DUAL_RAIL:   rail_cnt = {1'b0, digit_count, 1'b0};
      CODE_ONE_OF_FOUR: rail_cnt = {digit_count, 2'b00};
      default:          rail_cnt = 9'd0;
    endcase
    if (digit_count == 7'd0 || rail_cnt > 9'(MAX_RAILS)) begin
      rail_cnt = 9'd0;
    end
  end

  assign cfg_ok = (rail_cnt != 9'd0);

  // Per-rail and per-digit enables.
  always_comb begin
    for (int k = 0; k < 64; k++) begin
      rail_en[k] = (9'(k) < rail_cnt);
    end
    for (int b = 0; b < 32; b++) begin
      digit_en[b] = (7'(b) < digit_count);
    end
  end

  assign r = item.rails_in & rail_en;
  assign v = item.value_in;

  // Encode: range checks and rail patterns for all three codes.
  always_comb begin
    v_fit  = ({1'b0, v} < VALUE_LIMIT);
    over_n = ({25'd0, digit_count} <= v);
    pat_n  = 64'd1 << v[5:0];
    over_d = 1'b0;
    over_q = 1'b0;
    pat_d  = '0;
    pat_q  = '0;
    for (int b = 0; b < 32; b++) begin
      over_d         = over_d | (v[b] & ~digit_en[b]);
      over_q         = over_q | (v[b] & ~digit_en[b / 2]);
      pat_d[2*b]     = digit_en[b] & ~v[b];
      pat_d[2*b + 1] = digit_en[b] & v[b];
    end
    for (int b = 0; b < 16; b++) begin
      for (int k = 0; k < 4; k++) begin
        pat_q[4*b + k] = digit_en[b] & (v[2*b +: 2] == 2'(k));
      end
    end
  end

  always_comb begin
    case (code_type)
      CODE_ONE_OF_N: begin
        enc_ok  = ~over_n;
        enc_pat = pat_n;
      end
      CODE_DUAL_RAIL: begin
        enc_ok  = ~over_d;
        enc_pat = pat_d;
      end
      default: begin
        enc_ok  = ~over_q;
        enc_pat = pat_q;
      end
    endcase
    enc_ok = enc_ok & cfg_ok & v_fit;
  end

  // Decode: one-hot index, and per-digit neutral and multiple-high detection.
  always_comb begin
    onehot_n = ((r & (r - 64'd1)) == 64'd0);
    idx_n    = '0;
    for (int k = 0; k < 64; k++) begin
      if (r[k]) begin
        idx_n = idx_n | 6'(k);
      end
    end
    multi_d = 1'b0;
    neut_d  = 1'b0;
    live_d  = 1'b0;
    val_d   = '0;
    for (int b = 0; b < 32; b++) begin
      multi_d  = multi_d | (&r[2*b +: 2]);
      neut_d   = neut_d | (digit_en[b] & ~(|r[2*b +: 2]));
      live_d   = live_d | (|r[2*b +: 2]);
      val_d[b] = r[2*b + 1];
    end
    multi_q = 1'b0;
    neut_q  = 1'b0;
    live_q  = 1'b0;
    val_q   = '0;
    for (int b = 0; b < 16; b++) begin
      multi_q        = multi_q | ((r[4*b +: 4] & (r[4*b +: 4] - 4'd1)) != 4'd0);
      neut_q         = neut_q | (digit_en[b] & ~(|r[4*b +: 4]));
      live_q         = live_q | (|r[4*b +: 4]);
      val_q[2*b]     = r[4*b + 1] | r[4*b + 3];
      val_q[2*b + 1] = r[4*b + 2] | r[4*b + 3];
    end
  end

  always_comb begin
    case (code_type)
      CODE_ONE_OF_N: begin
        dec_err = ~onehot_n;
        dec_val = {26'd0, idx_n};
      end
      CODE_DUAL_RAIL: begin
        dec_err = multi_d | (neut_d & live_d);
        dec_val = val_d;
      end
      default: begin
        dec_err = multi_q | (neut_q & live_q);
        dec_val = val_q;
      end
    endcase
    if (!cfg_ok) begin
      dec_status = ST_RAILERR;
    end else if (r == 64'd0) begin
      dec_status = ST_NEUTRAL;
    end else if (dec_err) begin
      dec_status = ST_RAILERR;
    end else if ({1'b0, dec_val} >= VALUE_LIMIT) begin
      dec_status = ST_TOOBIG;
    end else begin
      dec_status = ST_VALID;
    end
  end

  // Result selection and the expected-value check.
  always_comb begin
    result.rails_out    = '0;
    result.value_out    = '0;
    result.check_result = CK_NONE;
    if (item.mode == MODE_ENCODE) begin
      result.status = enc_ok ? ST_VALID : ST_TOOBIG;
      if (enc_ok) begin
        result.rails_out = enc_pat;
      end
    end else begin
      result.status = dec_status;
      if (dec_status == ST_VALID) begin
        result.value_out = dec_val;
        if (item.mode == MODE_CHECK) begin
          if (item.expected == '1) begin
            result.check_result = CK_IGNORED;
          end else if (item.expected == {1'b0, dec_val}) begin
            result.check_result = CK_MATCH;
          end else begin
            result.check_result = CK_MISMATCH;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/dicc_checker.sv =====
// Port-level checks for the code converter, bound to the top level.
`timescale 1ns / 1ps

module dicc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dicc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dicc_pkg::*;

  // A result held back by the sink stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Any status other than valid comes with neutral rails and a zero value.
  a_bad_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[97:96] != ST_VALID |-> out_tdata[95:0] == 96'd0)
    else $error("payload not cleared on a failed status");

  // A check outcome is only reported for a valid decode with no rails raised.
  a_check_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[99:98] != CK_NONE
      |-> out_tdata[97:96] == ST_VALID && out_tdata[63:0] == 64'd0)
    else $error("check result on an encode or failed decode");

  // Encode and decode results never mix.
  a_encode_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63:0] != 64'd0 |-> out_tdata[95:64] == 32'd0)
    else $error("encoded rails together with a decoded value");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind delay_insensitive_code_converter dicc_checker u_dicc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/delay_insensitive_code_converter_tb.sv =====
// Self-checking testbench for the delay-insensitive code converter: encodes, decodes and checks.
`timescale 1ns / 1ps

module delay_insensitive_code_converter_tb;
  import dicc_pkg::*;

  // Item modes and code types that the package leaves unnamed.
  localparam logic [1:0] MODE_DECODE     = 2'd1;
  localparam logic [1:0] MODE_DECODE_ALT = 2'd3;
  localparam logic [1:0] CODE_RESERVED   = 2'd3;

  // An expected value of all ones means the comparison is skipped.
  localparam logic [32:0] EXPECT_IGNORE = 33'h1_FFFF_FFFF;

  // Register byte addresses.
  localparam logic [CFG_ADDR_W-1:0] ADDR_CODE_TYPE   = {REG_CODE_TYPE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_DIGIT_COUNT = {REG_DIGIT_COUNT, 2'b00};

  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  // Predicts each conversion and compares the block's results in order.
  class conversion_scoreboard;
    logic [1:0]   code_type;
    logic [6:0]   digit_count;
    dicc_result_t pending_conversions[$];
    int unsigned  mismatches;
    int unsigned  results_checked;

    function new();
      code_type       = CODE_ONE_OF_N;
      digit_count     = 7'd1;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    // Rails in use for the current setting; zero when the setting is unusable.
    function int unsigned rail_total();
      int unsigned r;
      if (digit_count == 0) return 0;
      case (code_type)
        CODE_ONE_OF_N:    r = digit_count;
        CODE_DUAL_RAIL:   r = 2 * digit_count;
        CODE_ONE_OF_FOUR: r = 4 * digit_count;
        default:          return 0;
      endcase
      if (r > MAX_RAILS) return 0;
      return r;
    endfunction

    // Number of values the current setting can carry.
    function logic [63:0] value_span();
      if (rail_total() == 0) return 64'd0;
      case (code_type)
        CODE_ONE_OF_N:  return 64'(digit_count);
        CODE_DUAL_RAIL: return 64'd1 << digit_count;
        default:        return 64'd1 << (2 * digit_count);
      endcase
    endfunction

    // Rail pattern of a value that fits the current setting.
    function logic [63:0] rail_pattern(logic [31:0] v);
      logic [63:0] pat;
      pat = '0;
      case (code_type)
        CODE_ONE_OF_N: pat[v[5:0]] = 1'b1;
        CODE_DUAL_RAIL: begin
          for (int b = 0; b < digit_count; b++) pat[2*b + v[b]] = 1'b1;
        end
        default: begin
          for (int b = 0; b < digit_count; b++) pat[4*b + 2*v[2*b+1] + v[2*b]] = 1'b1;
        end
      endcase
      return pat;
    endfunction

    function dicc_result_t convert(dicc_item_t it);
      dicc_result_t res;
      int unsigned  total;
      int unsigned  w;
      logic [63:0]  live;
      logic [63:0]  val;
      logic [63:0]  digit;
      logic         neutral_seen;
      logic         valid_seen;
      logic         broken;
      res.rails_out    = '0;
      res.value_out    = '0;
      res.check_result = CK_NONE;
      total            = rail_total();

      // Encode: a value that does not fit leaves every rail neutral.
      if (it.mode == MODE_ENCODE) begin
        if (total == 0 || it.value_in >= value_span()) begin
          res.status = ST_TOOBIG;
        end else begin
          res.status    = ST_VALID;
          res.rails_out = rail_pattern(it.value_in);
        end
        return res;
      end

      // Decode: rails above the configured count are dropped first.
      val          = '0;
      neutral_seen = 1'b0;
      valid_seen   = 1'b0;
      broken       = 1'b0;
      live         = (total >= 64) ? it.rails_in : it.rails_in & ((64'd1 << total) - 1);
      if (total == 0) begin
        res.status = ST_RAILERR;
      end else if (live == 0) begin
        res.status = ST_NEUTRAL;
      end else if (code_type == CODE_ONE_OF_N) begin
        if ($countones(live) != 1) begin
          res.status = ST_RAILERR;
        end else begin
          res.status = ST_VALID;
          for (int k = 0; k < 64; k++) if (live[k]) val = 64'(k);
        end
      end else begin
        w = (code_type == CODE_DUAL_RAIL) ? 2 : 4;
        for (int b = 0; b < digit_count; b++) begin
          digit = (live >> (w * b)) & ((64'd1 << w) - 1);
          if ($countones(digit) > 1) begin
            broken = 1'b1;
          end else if (digit == 0) begin
            neutral_seen = 1'b1;
          end else begin
            valid_seen = 1'b1;
            for (int k = 0; k < w; k++) if (digit[k]) val |= 64'(k) << ((w / 2) * b);
          end
        end
        // A mix of neutral and valid digits is as bad as a digit with two rails up.
        if (broken || (neutral_seen && valid_seen)) res.status = ST_RAILERR;
        else res.status = ST_VALID;
      end
      if (res.status == ST_VALID && val >= VALUE_LIMIT) res.status = ST_TOOBIG;

      if (res.status == ST_VALID) begin
        res.value_out = val[31:0];
        if (it.mode == MODE_CHECK) begin
          if (it.expected == EXPECT_IGNORE) res.check_result = CK_IGNORED;
          else if (!it.expected[32] && it.expected[31:0] == val[31:0])
            res.check_result = CK_MATCH;
          else res.check_result = CK_MISMATCH;
        end
      end
      return res;
    endfunction

    function int unsigned pending();
      return pending_conversions.size();
    endfunction

    task report(string what);
      if (mismatches < 100) $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    function void note_item(dicc_item_t it);
      pending_conversions.push_back(convert(it));
    endfunction

    task check_conversion(logic [63:0] rails, logic [31:0] value, logic [1:0] st,
                          logic [1:0] ck);
      dicc_result_t want;
      results_checked++;
      if (pending_conversions.size() == 0) begin
        report($sformatf("result %0d arrived with no item waiting", results_checked));
      end else begin
        want = pending_conversions.pop_front();
        if (rails !== want.rails_out)
          report($sformatf("result %0d rails_out %h, want %h", results_checked, rails,
                           want.rails_out));
        if (value !== want.value_out)
          report($sformatf("result %0d value_out %h, want %h", results_checked, value,
                           want.value_out));
        if (st !== want.status)
          report($sformatf("result %0d status %0d, want %0d", results_checked, st,
                           want.status));
        if (ck !== want.check_result)
          report($sformatf("result %0d check_result %0d, want %0d", results_checked, ck,
                           want.check_result));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  conversion_scoreboard sb;
  int send_gap_pct = 21;
  int recv_gap_pct = 60;
  bit hold_output  = 1'b0;
  int stall_cycles = 0;

  delay_insensitive_code_converter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Offer one item, with random gaps before it, and note it once the transfer happens.
  task automatic send_item(logic [1:0] mode, logic [31:0] value, logic [63:0] rails,
                           logic [32:0] expv);
    dicc_item_t it;
    it.mode     = mode;
    it.value_in = value;
    it.rails_in = rails;
    it.expected = expv;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {5'd0, expv, rails, value, mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Change the code setting once the block has delivered everything in flight.
  task automatic set_code(logic [1:0] ct, logic [6:0] dc);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    write_reg(ADDR_CODE_TYPE, CFG_DATA_W'(ct));
    write_reg(ADDR_DIGIT_COUNT, CFG_DATA_W'(dc));
    sb.code_type   = ct;
    sb.digit_count = dc;
  endtask

  // Mostly well-formed codes for the current setting, plus damaged ones and noise.
  task automatic random_item();
    logic [1:0]  mode;
    logic [31:0] value;
    logic [31:0] base;
    logic [63:0] rails;
    logic [63:0] clean;
    logic [63:0] mask;
    logic [63:0] span;
    logic [32:0] expv;
    int unsigned total;
    int unsigned pick;
    int unsigned w;
    int unsigned b;
    span           = sb.value_span();
    total          = sb.rail_total();
    mask           = (total >= 64) ? '1 : ((64'd1 << total) - 1);
    value          = $urandom;
    rails          = {$urandom, $urandom};
    expv[31:0]     = $urandom;
    expv[32]       = $urandom_range(1);
    if (span == 0 || span > 64'hFFFF_FFFF) base = $urandom;
    else base = $urandom_range(span[31:0] - 1);

    pick = $urandom_range(99);
    if (pick < 35) mode = MODE_ENCODE;
    else if (pick < 65) mode = MODE_DECODE;
    else if (pick < 95) mode = MODE_CHECK;
    else mode = MODE_DECODE_ALT;

    if (mode == MODE_ENCODE) begin
      // In range, at the top of the range, just past it, or any 32-bit value.
      pick = $urandom_range(9);
      if (span != 0 && pick < 6) value = base;
      else if (span != 0 && pick < 8 && span <= 64'hFFFF_FFFF)
        value = (pick == 6) ? span[31:0] - 1 : span[31:0];
    end else if (span != 0) begin
      pick  = $urandom_range(99);
      clean = sb.rail_pattern(base);
      w     = (sb.code_type == CODE_DUAL_RAIL) ? 2 : 4;
      if (pick < 55) begin
        rails = clean;
      end else if (pick < 62) begin
        rails = '0;
      end else if (pick < 72) begin
        // Drop one digit back to neutral.
        rails = clean;
        if (sb.code_type != CODE_ONE_OF_N) begin
          b = $urandom_range(sb.digit_count - 1);
          rails &= ~(((64'd1 << w) - 1) << (w * b));
        end
      end else if (pick < 86) begin
        // Raise one more rail, which may land in the same digit as a raised one.
        if (sb.code_type == CODE_ONE_OF_N) b = $urandom_range(total - 1);
        else b = w * $urandom_range(sb.digit_count - 1) + $urandom_range(w - 1);
        rails = clean | (64'd1 << b);
      end
      // Rails above the configured count must make no difference.
      if (pick < 86 && $urandom_range(1) == 1) rails |= {$urandom, $urandom} & ~mask;
    end

    if (mode == MODE_CHECK) begin
      pick = $urandom_range(99);
      if (pick < 45) expv = {1'b0, base};
      else if (pick < 60) expv = EXPECT_IGNORE;
      else if (pick < 70) expv[32] = 1'b1;
    end
    send_item(mode, value, rails, expv);
  endtask

  task automatic run_phase(logic [1:0] ct, logic [6:0] dc, int count);
    set_code(ct, dc);
    repeat (count) random_item();
  endtask

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_conversion(out_tdata[63:0], out_tdata[95:64], out_tdata[97:96],
                          out_tdata[99:98]);
  end

  // Stop a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // One rail: only zero encodes, and every rail above rail 0 is ignored.
    set_code(CODE_ONE_OF_N, 7'd1);
    send_item(MODE_ENCODE, 32'd0, '0, '0);
    send_item(MODE_ENCODE, 32'd1, '0, '0);
    send_item(MODE_DECODE, 32'hFFFF_FFFF, 64'd1, '0);
    send_item(MODE_CHECK, '0, '1, 33'd0);

    // Widest one-hot code: top value, first value past it, two rails up, all neutral.
    set_code(CODE_ONE_OF_N, 7'd64);
    send_item(MODE_ENCODE, 32'd63, '0, '0);
    send_item(MODE_ENCODE, 32'd64, '0, '0);
    send_item(MODE_CHECK, '0, 64'h8000_0000_0000_0000, 33'd63);
    send_item(MODE_DECODE, '0, 64'h0000_0000_0001_0001, '0);
    send_item(MODE_DECODE, '0, 64'd0, '0);

    // Full dual-rail word: ignored and negative expectations, a neutral digit, a bad digit.
    set_code(CODE_DUAL_RAIL, 7'd32);
    send_item(MODE_ENCODE, 32'hFFFF_FFFF, '0, '0);
    send_item(MODE_CHECK, '0, 64'hAAAA_AAAA_AAAA_AAAA, EXPECT_IGNORE);
    send_item(MODE_CHECK, '0, 64'h5555_5555_5555_5555, 33'h1_0000_0000);
    send_item(MODE_DECODE_ALT, '0, 64'h2AAA_AAAA_AAAA_AAAA, '0);
    send_item(MODE_DECODE, '0, 64'h5555_5555_5555_5557, '0);

    // Full one-of-four word: a plain mismatch and a digit with two rails up.
    set_code(CODE_ONE_OF_FOUR, 7'd16);
    send_item(MODE_ENCODE, 32'hFFFF_FFFF, '0, '0);
    send_item(MODE_CHECK, '0, 64'h8888_8888_8888_8888, 33'h0_FFFF_FFFE);
    send_item(MODE_DECODE, '0, 64'h8888_8888_8888_888C, '0);

    // Unusable settings: too many rails, reserved code, no digits.
    set_code(CODE_DUAL_RAIL, 7'd33);
    send_item(MODE_ENCODE, 32'd0, '0, '0);
    send_item(MODE_DECODE, '0, 64'd1, '0);
    set_code(CODE_RESERVED, 7'd2);
    send_item(MODE_ENCODE, 32'd0, '0, '0);
    send_item(MODE_CHECK, '0, 64'd1, 33'd0);
    set_code(CODE_ONE_OF_N, 7'd0);
    send_item(MODE_ENCODE, 32'd0, '0, '0);
    send_item(MODE_DECODE, '0, 64'd1, '0);

    // Random traffic, sender idling lightly and receiver heavily.
    run_phase(CODE_ONE_OF_N, 7'd8, 200);
    run_phase(CODE_DUAL_RAIL, 7'd4, 150);
    set_code(CODE_ONE_OF_FOUR, 7'd3);
    hold_output = 1'b1;
    repeat (150) random_item();
    run_phase(CODE_ONE_OF_N, 7'd64, 120);
    run_phase(CODE_DUAL_RAIL, 7'd32, 200);
    run_phase(CODE_ONE_OF_FOUR, 7'd16, 150);

    // Sender idling heavily, receiver lightly.
    send_gap_pct = 60;
    recv_gap_pct = 21;
    run_phase(CODE_DUAL_RAIL, 7'd1, 80);
    run_phase(CODE_ONE_OF_FOUR, 7'd1, 80);
    run_phase(CODE_ONE_OF_N, 7'd1, 60);
    run_phase(CODE_DUAL_RAIL, 7'd17, 120);
    run_phase(CODE_ONE_OF_FOUR, 7'd9, 120);

    // Full rate on both sides.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_phase(CODE_ONE_OF_N, 7'd37, 120);
    run_phase(CODE_RESERVED, 7'd4, 40);
    run_phase(CODE_DUAL_RAIL, 7'd33, 40);
    run_phase(CODE_ONE_OF_FOUR, 7'd127, 30);
    run_phase(CODE_ONE_OF_N, 7'd0, 30);

    // Drain, then give the pipeline time to show any stray result.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dicc_pkg.sv
rtl/dicc_core.sv
rtl/delay_insensitive_code_converter.sv
rtl/dicc_checker.sv
tb/delay_insensitive_code_converter_tb.sv
